// ----- src/rmq_pkg.sv -----
// rmq_pkg: shared types and constants for the rotation matrix to quaternion block
// no dependencies; imported by every module of the block
`default_nettype none

package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int COMP_W        = 16;
    localparam int NUM_W         = 17;
    localparam int QUOT_W        = 16;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef struct packed {
        logic signed [COMP_W-1:0] r00;
        logic signed [COMP_W-1:0] r01;
        logic signed [COMP_W-1:0] r02;
        logic signed [COMP_W-1:0] r10;
        logic signed [COMP_W-1:0] r11;
        logic signed [COMP_W-1:0] r12;
        logic signed [COMP_W-1:0] r20;
        logic signed [COMP_W-1:0] r21;
        logic signed [COMP_W-1:0] r22;
    } in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] quat_w;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_z;
        logic [1:0]               branch_taken;
        logic                     degenerate;
    } out_t;

    // numerators and branch info riding along the root pipeline
    typedef struct packed {
        logic signed [NUM_W-1:0] n_w;
        logic signed [NUM_W-1:0] n_x;
        logic signed [NUM_W-1:0] n_y;
        logic signed [NUM_W-1:0] n_z;
        logic [1:0]              branch;
        logic                    degen;
    } sq_side_t;

    // signs, dominant value and branch info riding along the divider pipeline
    typedef struct packed {
        logic [3:0]        neg;
        logic [COMP_W-1:0] dom;
        logic [1:0]        branch;
        logic              degen;
    } div_side_t;

endpackage

`default_nettype wire

// ----- src/rotation_matrix_to_quaternion.sv -----
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion, fixed point
// uses rmq_pkg, rmq_sqrt and rmq_div
//
//   channel   ports                      payload
//   input     s_valid s_ready s_data     in_t  : r00 .. r22
//   result    m_valid m_ready m_data     out_t : quat_w..quat_z, branch_taken, degenerate
//
// one item enters per cycle while s_ready is high; the pipeline stages are, in order:
// decode, one stage per root bit, one per quotient bit plus an overflow stage, output
// ROOT_W is 16 at FRAC_BITS = 14, and the root and divider stages set the depth
// aresetn clears only the valid bits; data registers carry no reset
// the whole pipeline advances together; when a result waits on m_ready it holds,
// and s_ready drops only while the output register is full and not taken
`default_nettype none

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    // radicand width: one plus up to three entries, or one itself
    localparam int RAD_W   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int RS_W    = RAD_W + 1;
    localparam int SQ_IN_W = RAD_W + FRAC_BITS;
    localparam int SQ_W    = SQ_IN_W + (SQ_IN_W % 2);
    localparam int ROOT_W  = SQ_W / 2;
    localparam int DW      = ROOT_W + 1;
    localparam int NW      = FRAC_BITS + NUM_W + 1;
    localparam int DEPTH   = ROOT_W + QUOT_W + 3;

    localparam logic [COMP_W-1:0] LIM =
        (FRAC_BITS >= 15) ? COMP_W'(32767) : COMP_W'(1 << FRAC_BITS);
    localparam logic signed [RS_W-1:0] ONE = RS_W'(1) << FRAC_BITS;

    // ---------------- pipeline control ----------------
    logic             adv;
    logic [DEPTH-1:0] vld_reg;

    assign adv     = m_ready || !vld_reg[DEPTH-1];
    assign s_ready = adv;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // ---------------- decode: trace, branch, radicand, numerators ----------------
    logic signed [RS_W-1:0] e00, e11, e22, tr, rad_s;
    logic [1:0]             br;
    logic signed [NUM_W-1:0] nw, nx, ny, nz;
    logic                   degen;
    logic [RAD_W-1:0]       rad_u;

    logic [RAD_W-1:0] dec_rad_reg;
    sq_side_t         dec_side_reg;

    always_comb begin
        e00 = RS_W'(s_data.r00);
        e11 = RS_W'(s_data.r11);
        e22 = RS_W'(s_data.r22);
        tr  = e00 + e11 + e22;
        nw  = '0;
        nx  = '0;
        ny  = '0;
        nz  = '0;
        // strict compares: ties fall through to the later branch
        priority if (tr > 0) begin
            br    = BR_TRACE;
            rad_s = tr + ONE;
            nx    = NUM_W'(s_data.r21) - NUM_W'(s_data.r12);
            ny    = NUM_W'(s_data.r02) - NUM_W'(s_data.r20);
            nz    = NUM_W'(s_data.r10) - NUM_W'(s_data.r01);
        end else if (s_data.r00 > s_data.r11 && s_data.r00 > s_data.r22) begin
            br    = BR_X;
            rad_s = ONE + e00 - e11 - e22;
            nw    = NUM_W'(s_data.r21) - NUM_W'(s_data.r12);
            ny    = NUM_W'(s_data.r01) + NUM_W'(s_data.r10);
            nz    = NUM_W'(s_data.r02) + NUM_W'(s_data.r20);
        end else if (s_data.r11 > s_data.r22) begin
            br    = BR_Y;
            rad_s = ONE + e11 - e00 - e22;
            nw    = NUM_W'(s_data.r02) - NUM_W'(s_data.r20);
            nx    = NUM_W'(s_data.r01) + NUM_W'(s_data.r10);
            nz    = NUM_W'(s_data.r12) + NUM_W'(s_data.r21);
        end else begin
            br    = BR_Z;
            rad_s = ONE + e22 - e00 - e11;
            nw    = NUM_W'(s_data.r10) - NUM_W'(s_data.r01);
            nx    = NUM_W'(s_data.r02) + NUM_W'(s_data.r20);
            ny    = NUM_W'(s_data.r12) + NUM_W'(s_data.r21);
        end
        degen = rad_s[RS_W-1] || (rad_s == '0);
        // a degenerate item runs a zero radicand through, its result is forced to zero
        rad_u = degen ? '0 : rad_s[RAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dec_rad_reg         <= rad_u;
            dec_side_reg.n_w    <= nw;
            dec_side_reg.n_x    <= nx;
            dec_side_reg.n_y    <= ny;
            dec_side_reg.n_z    <= nz;
            dec_side_reg.branch <= br;
            dec_side_reg.degen  <= degen;
        end
    end

    // ---------------- square root of rad * ONE ----------------
    logic [SQ_W-1:0]   sq_x;
    logic [ROOT_W-1:0] root;
    sq_side_t          sq_side_reg [ROOT_W];

    assign sq_x = SQ_W'({dec_rad_reg, {FRAC_BITS{1'b0}}});

    rmq_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .aclk (aclk),
        .en   (adv),
        .x_in (sq_x),
        .root (root)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_side_reg[0] <= dec_side_reg;
            for (int i = 1; i < ROOT_W; i++) begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    // ---------------- divider entry: magnitudes, dominant component ----------------
    // rounded num * ONE / 2R equals floor((|num| * ONE + R) / 2R)
    sq_side_t                sq_out;
    logic signed [NUM_W-1:0] num_s [4];
    logic [NUM_W-1:0]        mag   [4];
    logic [NW-1:0]           dnum  [4];
    logic [DW-1:0]           dden;
    logic [3:0]              neg;
    logic [ROOT_W:0]         dom_full;
    logic [COMP_W-1:0]       dom_sat;

    always_comb begin
        sq_out   = sq_side_reg[ROOT_W-1];
        num_s[0] = sq_out.n_w;
        num_s[1] = sq_out.n_x;
        num_s[2] = sq_out.n_y;
        num_s[3] = sq_out.n_z;
        dden     = {root, 1'b0};
        for (int c = 0; c < 4; c++) begin
            neg[c]  = num_s[c][NUM_W-1];
            mag[c]  = neg[c] ? NUM_W'(-num_s[c]) : NUM_W'(num_s[c]);
            dnum[c] = NW'({mag[c], {FRAC_BITS{1'b0}}}) + NW'(root);
        end
        // dominant component: R / 2 rounded half up
        dom_full = ((ROOT_W + 1)'(root) + (ROOT_W + 1)'(1)) >> 1;
        dom_sat  = (dom_full > (ROOT_W + 1)'(LIM)) ? LIM : COMP_W'(dom_full);
    end

    logic [QUOT_W-1:0] quot [4];
    logic [3:0]        q_ovf;

    for (genvar c = 0; c < 4; c++) begin : g_div
        rmq_div #(
            .NW (NW),
            .DW (DW),
            .QW (QUOT_W)
        ) u_div (
            .aclk (aclk),
            .en   (adv),
            .num  (dnum[c]),
            .den  (dden),
            .quot (quot[c]),
            .ovf  (q_ovf[c])
        );
    end

    div_side_t div_side_reg [QUOT_W+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_side_reg[0].neg    <= neg;
            div_side_reg[0].dom    <= dom_sat;
            div_side_reg[0].branch <= sq_out.branch;
            div_side_reg[0].degen  <= sq_out.degen;
            for (int i = 1; i <= QUOT_W; i++) begin
                div_side_reg[i] <= div_side_reg[i-1];
            end
        end
    end

    // ---------------- saturate, sign, select dominant, output register ----------------
    div_side_t         dv;
    logic [COMP_W-1:0] cmag [4];
    logic [COMP_W-1:0] cval [4];
    out_t              m_data_next;
    out_t              m_data_reg;

    always_comb begin
        dv = div_side_reg[QUOT_W];
        for (int c = 0; c < 4; c++) begin
            if (dv.branch == 2'(c)) begin
                cmag[c] = dv.dom;
            end else if (q_ovf[c] || quot[c] > QUOT_W'(LIM)) begin
                cmag[c] = LIM;
            end else begin
                cmag[c] = COMP_W'(quot[c]);
            end
            if (dv.degen) begin
                cval[c] = '0;
            end else if (dv.neg[c] && dv.branch != 2'(c)) begin
                cval[c] = -cmag[c];
            end else begin
                cval[c] = cmag[c];
            end
        end
        m_data_next.quat_w       = cval[0];
        m_data_next.quat_x       = cval[1];
        m_data_next.quat_y       = cval[2];
        m_data_next.quat_z       = cval[3];
        m_data_next.branch_taken = dv.branch;
        m_data_next.degenerate   = dv.degen;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_data = m_data_reg;

`ifndef SYNTHESIS
    // a degenerate result carries an all-zero quaternion
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.quat_w == 0 && m_data.quat_x == 0 &&
            m_data.quat_y == 0 && m_data.quat_z == 0)
        else $error("degenerate result with nonzero quaternion");

    // the dominant component of a proper result is strictly positive
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.degenerate |->
            (m_data.branch_taken == BR_TRACE && m_data.quat_w > 0) ||
            (m_data.branch_taken == BR_X && m_data.quat_x > 0) ||
            (m_data.branch_taken == BR_Y && m_data.quat_y > 0) ||
            (m_data.branch_taken == BR_Z && m_data.quat_z > 0))
        else $error("dominant component not positive");

    // every component stays within the saturation limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_data.quat_w <= $signed({1'b0, LIM}) && m_data.quat_w >= -$signed({1'b0, LIM}) &&
            m_data.quat_x <= $signed({1'b0, LIM}) && m_data.quat_x >= -$signed({1'b0, LIM}) &&
            m_data.quat_y <= $signed({1'b0, LIM}) && m_data.quat_y >= -$signed({1'b0, LIM}) &&
            m_data.quat_z <= $signed({1'b0, LIM}) && m_data.quat_z >= -$signed({1'b0, LIM}))
        else $error("component outside saturation range");
`endif

endmodule

`default_nettype wire

// ----- src/rmq_sqrt.sv -----
// rmq_sqrt: pipelined restoring integer square root, one root bit per stage
// uses rmq_pkg
`default_nettype none

module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int ROOT_W = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [2*ROOT_W-1:0]   x_in,
    output logic      [ROOT_W-1:0]     root
);

    localparam int IN_W  = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;
    localparam int TMP_W = ROOT_W + 3;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [IN_W-1:0]   x_reg    [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [IN_W-1:0]   x_cur;
        logic [TMP_W-1:0]  tmp;
        logic [TMP_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [IN_W-1:0]   x_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_cur   = x_in;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign x_cur   = x_reg[k-1];
        end

        always_comb begin
            tmp       = {rem_in, x_cur[IN_W-1 -: 2]};
            trial     = TMP_W'({root_in, 2'b01});
            ge        = tmp >= trial;
            rem_next  = ge ? REM_W'(tmp - trial) : REM_W'(tmp);
            root_next = {root_in[ROOT_W-2:0], ge};
            x_next    = x_cur << 2;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                x_reg[k]    <= x_next;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ----- src/rmq_div.sv -----
// rmq_div: pipelined restoring divider, one quotient bit per stage, with overflow flag
// uses rmq_pkg
`default_nettype none

module rmq_div
    import rmq_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 17,
    parameter int QW = QUOT_W
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quot,
    output logic               ovf
);

    localparam int HI_W = NW - QW;
    localparam int CW   = (HI_W > DW) ? HI_W : DW;

    logic [DW-1:0] rem_reg [QW+1];
    logic [DW-1:0] d_reg   [QW+1];
    logic [QW-1:0] lo_reg  [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic          ovf_reg [QW+1];

    logic [CW-1:0] hi;
    logic          ovf_first;

    // quotient would need more than QW bits when the top part already reaches den
    always_comb begin
        hi        = CW'(num[NW-1:QW]);
        ovf_first = hi >= CW'(den);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DW'(hi);
            d_reg[0]   <= den;
            lo_reg[0]  <= num[QW-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_first;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_stage
        logic [DW:0]   tmp;
        logic          ge;
        logic [DW-1:0] rem_next;

        always_comb begin
            tmp      = {rem_reg[j-1], lo_reg[j-1][QW-1]};
            ge       = tmp >= {1'b0, d_reg[j-1]};
            rem_next = ge ? DW'(tmp - {1'b0, d_reg[j-1]}) : DW'(tmp);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                d_reg[j]   <= d_reg[j-1];
                lo_reg[j]  <= lo_reg[j-1] << 1;
                q_reg[j]   <= {q_reg[j-1][QW-2:0], ge};
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign quot = q_reg[QW];
    assign ovf  = ovf_reg[QW];

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking bench for rotation_matrix_to_quaternion, random matrices with bursty
// input and stalling output, results predicted in place; depends on rmq_pkg and the block
`timescale 1ns / 1ps

module tb;
    import rmq_pkg::*;

    localparam int FRAC   = 14;
    localparam int ONE    = 1 << FRAC;
    localparam int LIM    = (ONE > 32767) ? 32767 : ONE;
    // root stages + quotient stages + decode/overflow/output
    localparam int LATENCY = 16 + QUOT_W + 3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    always #1 aclk = ~aclk;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    in_t  pending_mats[$];     // matrices waiting to be offered
    out_t quat_expected[$];    // predicted quaternions in acceptance order
    int   mismatches = 0;
    bit   pause_req = 1'b0;    // sender holds off while set
    bit   long_stall = 1'b0;   // receiver holds off while set

    // append a matrix to the tail of the pending queue
    function automatic void add_pending(in_t m);
        pending_mats.insert(pending_mats.size(), m);
    endfunction

    // append a prediction to the tail of the expected queue
    function automatic void add_expected(out_t q);
        quat_expected.insert(quat_expected.size(), q);
    endfunction

    // integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp_lim(longint v);
        if (v > LIM) return LIM;
        if (v < -LIM) return -LIM;
        return v;
    endfunction

    // num * ONE / d, nearest, ties away from zero
    function automatic longint scaled_quot(longint num, longint unsigned d);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (2 * mag * ONE + d) / (2 * d);
        return clamp_lim((num < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic out_t quat_of_matrix(in_t m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad;
        longint nm[4];
        longint qv[4];
        longint unsigned root;
        logic [1:0] br;
        out_t o;
        a00 = m.r00; a01 = m.r01; a02 = m.r02;
        a10 = m.r10; a11 = m.r11; a12 = m.r12;
        a20 = m.r20; a21 = m.r21; a22 = m.r22;
        tr = a00 + a11 + a22;
        nm[0] = 0; nm[1] = 0; nm[2] = 0; nm[3] = 0;
        if (tr > 0) begin
            br = BR_TRACE; rad = tr + ONE;
            nm[1] = a21 - a12; nm[2] = a02 - a20; nm[3] = a10 - a01;
        end else if (a00 > a11 && a00 > a22) begin
            br = BR_X; rad = ONE + a00 - a11 - a22;
            nm[0] = a21 - a12; nm[2] = a01 + a10; nm[3] = a02 + a20;
        end else if (a11 > a22) begin
            br = BR_Y; rad = ONE + a11 - a00 - a22;
            nm[0] = a02 - a20; nm[1] = a01 + a10; nm[3] = a12 + a21;
        end else begin
            br = BR_Z; rad = ONE + a22 - a00 - a11;
            nm[0] = a10 - a01; nm[1] = a02 + a20; nm[2] = a12 + a21;
        end
        for (int i = 0; i < 4; i++) qv[i] = 0;
        if (rad > 0) begin
            root = root_floor(longint'(rad) << FRAC);
            for (int i = 0; i < 4; i++)
                qv[i] = (i == br) ? clamp_lim(longint'((root + 1) >> 1))
                                  : scaled_quot(nm[i], 2 * root);
        end
        o.quat_w = qv[0][15:0];
        o.quat_x = qv[1][15:0];
        o.quat_y = qv[2][15:0];
        o.quat_z = qv[3][15:0];
        o.branch_taken = br;
        o.degenerate = (rad <= 0);
        return o;
    endfunction

    function automatic logic signed [15:0] rand_entry();
        case ($urandom_range(0, 9))
            0: return 16'(ONE);
            1: return -16'(ONE);
            2: return 16'($urandom);             // anything, out of range too
            3: return 16'($urandom_range(0, 8)) - 16'sd4;
            default: return 16'($urandom_range(0, 2 * ONE)) - 16'(ONE);
        endcase
    endfunction

    // proper rotation built from a permutation with signs, then perturbed
    function automatic in_t rand_rotation();
        logic signed [15:0] e[9];
        int p, sgn[3], det_fix;
        in_t m;
        int perms[6][3] = '{'{0,1,2}, '{1,2,0}, '{2,0,1}, '{0,2,1}, '{2,1,0}, '{1,0,2}};
        p = $urandom_range(0, 5);
        for (int i = 0; i < 3; i++) sgn[i] = $urandom_range(0, 1) ? 1 : -1;
        det_fix = (p < 3) ? 1 : -1;
        if (sgn[0] * sgn[1] * sgn[2] != det_fix) sgn[2] = -sgn[2];
        for (int i = 0; i < 9; i++) e[i] = 0;
        for (int r = 0; r < 3; r++)
            e[r * 3 + perms[p][r]] = 16'(sgn[r] * ONE);
        for (int i = 0; i < 9; i++)
            e[i] = e[i] - 16'(int'($urandom_range(0, 8000)) * ((e[i] > 0) ? 1 : -1))
                   + ((e[i] == 0) ? 16'($urandom_range(0, 12000)) - 16'sd6000 : 16'sd0);
        m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return m;
    endfunction

    function automatic in_t diag(int a, int b, int c);
        in_t m;
        m = '0;
        m.r00 = 16'(a); m.r11 = 16'(b); m.r22 = 16'(c);
        return m;
    endfunction

    // driver: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pause_req || pending_mats.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                s_data <= pending_mats.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // predict on acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            add_expected(quat_of_matrix(s_data));
    end

    // receiver: stall pattern of its own, with quiet stretches
    int stall_mode = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            if (long_stall) m_ready <= 1'b0;
            else case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (quat_expected.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result %h", m_data);
            end else begin
                want = quat_expected.pop_front();
                if (want !== m_data) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0d",
                                 want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                                 want.branch_taken, want.degenerate);
                        $display("          act w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0d",
                                 m_data.quat_w, m_data.quat_x, m_data.quat_y, m_data.quat_z,
                                 m_data.branch_taken, m_data.degenerate);
                    end
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps going
    initial begin
        wait (aresetn);
        repeat (300) @(posedge aclk);
        long_stall = 1'b1;
        repeat (LATENCY * 3) @(posedge aclk);
        long_stall = 1'b0;
    end

    initial begin
        in_t m;
        // identity and its half-turns, one per branch
        add_pending(diag(ONE, ONE, ONE));
        add_pending(diag(ONE, -ONE, -ONE));
        add_pending(diag(-ONE, ONE, -ONE));
        add_pending(diag(-ONE, -ONE, ONE));
        // diagonal ties
        add_pending(diag(-ONE, -ONE, -ONE));
        add_pending(diag(0, 0, 0));
        add_pending(diag(-100, -100, -200));
        add_pending(diag(-200, -100, -100));
        add_pending(diag(-100, -200, -100));
        // zero trace boundary and negative traces with tied or extreme diagonals
        add_pending(diag(ONE, 0, -ONE));
        add_pending(diag(-ONE, -ONE, -ONE - 2000));
        add_pending(diag(-32768, -32768, -32768));
        // field extremes, saturating off-diagonals
        m = '{default: 16'sh7fff};
        add_pending(m);
        m = '{default: 16'sh8000};
        add_pending(m);
        m = diag(-ONE, -ONE, -ONE + 20);
        m.r12 = 16'sh8000; m.r21 = 16'sh7fff; m.r02 = 16'sh7fff; m.r20 = 16'sh7fff;
        add_pending(m);
        m = '{default: 16'shffff};
        add_pending(m);
        m = diag(ONE, ONE, ONE);
        m.r01 = 16'sh5555; m.r10 = 16'shaaaa;
        add_pending(m);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 1400; i++) begin
            if ($urandom_range(0, 3) != 0) m = rand_rotation();
            else m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                      rand_entry(), rand_entry(), rand_entry(), rand_entry()};
            add_pending(m);
            // one drain pause midway
            if (i == 700) begin
                while (pending_mats.size() != 0) @(posedge aclk);
                pause_req = 1'b1;
                while (s_valid || quat_expected.size() != 0) @(posedge aclk);
                pause_req = 1'b0;
            end
        end
        while (pending_mats.size() != 0 || s_valid) @(posedge aclk);
        while (quat_expected.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && quat_expected.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
